// ===== hdl/spcp_pkg.sv =====
// Package for the serial PWM command parser: reply codes, character codes,
// queue entry types and the constants of the duty scaling.
// Depends on nothing; every other file of the block imports it.
package spcp_pkg;

	// Reply codes as they appear on the result port.
	typedef enum logic [2:0] {
		RPL_ENABLED  = 3'd0,
		RPL_DISABLED = 3'd1,
		RPL_STATUS   = 3'd2,
		RPL_DUTY_SET = 3'd3,
		RPL_REJECTED = 3'd4,
		RPL_UNKNOWN  = 3'd5
	} reply_kind_t;

	// Phases of the decimal number reader.
	typedef enum logic [1:0] {
		NUM_SKIP   = 2'd0,
		NUM_DIGITS = 2'd1,
		NUM_DONE   = 2'd2
	} num_phase_t;

	// Character codes.
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_D     = 8'h44;
	localparam logic [7:0] CHAR_L     = 8'h4C;
	localparam logic [7:0] CHAR_P     = 8'h50;
	localparam logic [7:0] CHAR_S     = 8'h53;
	// Clearing bit 5 folds a lower-case letter onto its capital.
	localparam logic [7:0] CASE_MASK  = 8'hDF;

	// Largest percentage that is accepted.
	localparam logic [7:0] PERCENT_MAX = 8'd100;

	// Division by one hundred as a multiplication: ceil(2^30 / 100).
	// Exact for every product of a 16-bit full scale and a percentage up to 100.
	localparam logic [23:0] RECIP_100   = 24'd10737419;
	localparam int          RECIP_SHIFT = 30;

	// Reset values of the registers of the back end.
	localparam logic [15:0] FULL_SCALE_RESET = 16'd1000;
	localparam logic [15:0] DUTY_RESET       = 16'd1;

	// Depth of both queues.
	localparam int QUEUE_DEPTH = 4;

	// A decoded command as the front end hands it on.
	typedef struct packed {
		reply_kind_t kind;
		logic [7:0]  pct;
	} cmd_t;

	// One result word.
	typedef struct packed {
		reply_kind_t kind;
		logic        pwm_on;
		logic [15:0] duty;
		logic [7:0]  pct;
	} result_t;

endpackage

// ===== hdl/spcp_fifo.sv =====
// Small first-in first-out queue built from registers, used between the
// front and back ends and in front of the result port.
// Depends on spcp_pkg for nothing but house style; DEPTH must be a power of two.
module spcp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	import spcp_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);
	localparam logic [CNTW-1:0] COUNT_FULL = CNTW'(DEPTH);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == COUNT_FULL);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = store_q[rd_ptr_q];

	// Entry storage; the contents need no reset.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/spcp_front.sv =====
// Front end of the serial PWM command parser: collects the bytes of a line,
// reads the number after P and classifies the line when it ends.
// Depends on spcp_pkg.
module spcp_front #(
	parameter int LINE_CAPACITY = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_valid,
	input  logic [7:0]    rx_byte,
	output logic          cmd_valid,
	output spcp_pkg::cmd_t cmd
);
	import spcp_pkg::*;

	localparam int CW = $clog2(LINE_CAPACITY);
	localparam logic [CW-1:0] KEEP_MAX = CW'(LINE_CAPACITY - 1);

	logic [CW-1:0] kept_count_q, kept_count_d;
	logic [7:0]    first_char_q, first_char_d;
	logic          text_ended_q, text_ended_d;
	logic          text_long_q, text_long_d;
	num_phase_t    phase_q, phase_d;
	logic          negative_q, negative_d;
	logic [7:0]    accum_q, accum_d;

	logic       is_eol;
	logic       is_blank;
	logic       is_digit;
	logic       is_sign;
	logic [7:0] digit_val;
	logic [7:0] accum_times_ten;
	logic [7:0] pct_val;
	logic [7:0] first_upper;

	// Character classes of the incoming byte.
	assign is_eol    = (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR);
	assign is_blank  = (rx_byte == CHAR_SPACE) || ((rx_byte >= CHAR_TAB) && (rx_byte <= CHAR_CR));
	assign is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
	assign is_sign   = (rx_byte == CHAR_PLUS) || (rx_byte == CHAR_MINUS);
	assign digit_val = rx_byte - CHAR_ZERO;
	assign accum_times_ten = {accum_q[4:0], 3'b000} + {accum_q[6:0], 1'b0};

	// Line state update for an accepted byte.
	always_comb begin
		kept_count_d = kept_count_q;
		first_char_d = first_char_q;
		text_ended_d = text_ended_q;
		text_long_d  = text_long_q;
		phase_d      = phase_q;
		negative_d   = negative_q;
		accum_d      = accum_q;
		cmd_valid    = 1'b0;
		if (byte_valid) begin
			if (is_eol) begin
				if (kept_count_q != '0) begin
					// A line whose text is empty gives no command.
					cmd_valid    = (first_char_q != CHAR_NUL);
					kept_count_d = '0;
					first_char_d = CHAR_NUL;
					text_ended_d = 1'b0;
					text_long_d  = 1'b0;
					phase_d      = NUM_SKIP;
					negative_d   = 1'b0;
					accum_d      = '0;
				end
			end else if (kept_count_q < KEEP_MAX) begin
				kept_count_d = kept_count_q + 1'b1;
				if (!text_ended_q) begin
					if (rx_byte == CHAR_NUL) begin
						text_ended_d = 1'b1;
					end else if (kept_count_q == '0) begin
						first_char_d = rx_byte;
					end else begin
						text_long_d = 1'b1;
						// Decimal reader: blanks, one sign, then digits.
						case (phase_q)
							NUM_SKIP: begin
								if (!is_blank) begin
									if (is_sign) begin
										negative_d = (rx_byte == CHAR_MINUS);
										phase_d    = NUM_DIGITS;
									end else if (is_digit) begin
										accum_d = digit_val;
										phase_d = NUM_DIGITS;
									end else begin
										phase_d = NUM_DONE;
									end
								end
							end
							NUM_DIGITS: begin
								if (is_digit) begin
									accum_d = accum_times_ten + digit_val;
								end else begin
									phase_d = NUM_DONE;
								end
							end
							default: begin
								phase_d = phase_q;
							end
						endcase
					end
				end
			end
		end
	end

	// Classification of the finished line.
	assign pct_val     = negative_q ? (8'd0 - accum_q) : accum_q;
	assign first_upper = first_char_q & CASE_MASK;

	always_comb begin
		cmd.pct = '0;
		if ((first_upper == CHAR_L) && !text_long_q) begin
			cmd.kind = RPL_ENABLED;
		end else if ((first_upper == CHAR_D) && !text_long_q) begin
			cmd.kind = RPL_DISABLED;
		end else if ((first_upper == CHAR_S) && !text_long_q) begin
			cmd.kind = RPL_STATUS;
		end else if (first_upper == CHAR_P) begin
			cmd.pct  = pct_val;
			cmd.kind = (pct_val <= PERCENT_MAX) ? RPL_DUTY_SET : RPL_REJECTED;
		end else begin
			cmd.kind = RPL_UNKNOWN;
		end
	end

	// Line state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_count_q <= '0;
			first_char_q <= CHAR_NUL;
			text_ended_q <= 1'b0;
			text_long_q  <= 1'b0;
			phase_q      <= NUM_SKIP;
			negative_q   <= 1'b0;
			accum_q      <= '0;
		end else begin
			kept_count_q <= kept_count_d;
			first_char_q <= first_char_d;
			text_ended_q <= text_ended_d;
			text_long_q  <= text_long_d;
			phase_q      <= phase_d;
			negative_q   <= negative_d;
			accum_q      <= accum_d;
		end
	end

endmodule

// ===== hdl/spcp_back.sv =====
// Back end of the serial PWM command parser: scales the duty in a two-stage
// multiply pipeline and commits commands to the enable flag and duty register.
// Depends on spcp_pkg.
module spcp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_data,
	input  logic             cmd_empty,
	input  spcp_pkg::cmd_t   cmd,
	output logic             cmd_pop,
	input  logic             res_full,
	output logic             res_push,
	output spcp_pkg::result_t res
);
	import spcp_pkg::*;

	logic [15:0] full_scale_q;
	logic        enable_q;
	logic [15:0] duty_q;

	logic        advance;
	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [23:0] prod_s1;
	logic        valid_s2;
	cmd_t        cmd_s2;
	logic [47:0] scaled_s2;

	logic        enable_next;
	logic [15:0] duty_next;

	// The whole pipeline moves unless the result queue is full.
	assign advance = !res_full;
	assign cmd_pop = advance && !cmd_empty;

	// Stage 1: full scale times percentage. Stage 2: times the reciprocal of 100.
	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s1    <= cmd;
			prod_s1   <= full_scale_q * cmd.pct;
			cmd_s2    <= cmd_s1;
			scaled_s2 <= prod_s1 * RECIP_100;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= cmd_pop;
			valid_s2 <= valid_s1;
		end
	end

	// Commit: the state changes in command order at the end of stage 2.
	always_comb begin
		enable_next = enable_q;
		duty_next   = duty_q;
		case (cmd_s2.kind)
			RPL_ENABLED:  enable_next = 1'b1;
			RPL_DISABLED: enable_next = 1'b0;
			RPL_DUTY_SET: duty_next   = scaled_s2[RECIP_SHIFT +: 16];
			default:      enable_next = enable_q;
		endcase
	end

	assign res_push   = valid_s2 && advance;
	assign res.kind   = cmd_s2.kind;
	assign res.pwm_on = enable_next;
	assign res.duty   = duty_next;
	assign res.pct    = cmd_s2.pct;

	// Configuration and command state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= FULL_SCALE_RESET;
			enable_q     <= 1'b1;
			duty_q       <= DUTY_RESET;
		end else begin
			if (cfg_we) begin
				full_scale_q <= cfg_data;
			end
			if (res_push) begin
				enable_q <= enable_next;
				duty_q   <= duty_next;
			end
		end
	end

endmodule

// ===== hdl/serial_pwm_command_parser.sv =====
// Top level of the serial PWM command parser: front end, command queue,
// back end and result queue. Depends on spcp_pkg, spcp_fifo, spcp_front, spcp_back.
//
// Channel   Direction  Handshake           Payload
// input     in         push / full         rx_byte
// result    out        empty / pop         reply_kind, pwm_on, duty_target, percent_value
// config    in         cfg_valid/cfg_ready cfg_data (duty full scale)
//
// One byte is taken in every cycle while the four-entry command queue has room.
// A line end's command passes the command queue and both multiply stages of the
// back end; commands go through the back end one per cycle while the result queue
// has room. cfg_ready is always high. Reset is asynchronous and clears both queues.
// A full result queue stalls the back end; once the command queue fills, full rises.
module serial_pwm_command_parser #(
	parameter int LINE_CAPACITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  reply_kind,
	output logic        pwm_on,
	output logic [15:0] duty_target,
	output logic [7:0]  percent_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import spcp_pkg::*;

	logic    byte_valid;
	logic    cmd_valid;
	cmd_t    cmd_in;
	cmd_t    cmd_out;
	logic    cmd_full;
	logic    cmd_empty;
	logic    cmd_pop;
	logic    res_full;
	logic    res_push;
	result_t res_in;
	result_t res_out;

	assign full       = cmd_full;
	assign byte_valid = push && !cmd_full;
	assign cfg_ready  = 1'b1;

	// Line collection and classification.
	spcp_front #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.rx_byte   (rx_byte),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_in)
	);

	// Command queue between the two ends.
	spcp_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_valid),
		.wr_data(cmd_in),
		.full   (cmd_full),
		.rd_en  (cmd_pop),
		.rd_data(cmd_out),
		.empty  (cmd_empty)
	);

	// Duty scaling and command commit.
	spcp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid),
		.cfg_data (cfg_data),
		.cmd_empty(cmd_empty),
		.cmd      (cmd_out),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	// Result queue in front of the output port.
	spcp_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_in),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(res_out),
		.empty  (empty)
	);

	assign reply_kind    = res_out.kind;
	assign pwm_on        = res_out.pwm_on;
	assign duty_target   = res_out.duty;
	assign percent_value = res_out.pct;

endmodule

// ===== hdl/spcp_checker.sv =====
// Port-level checks of the serial PWM command parser, attached by bind.
// Depends on spcp_pkg and on the top level serial_pwm_command_parser.
module spcp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [2:0]  reply_kind,
	input logic        pwm_on,
	input logic [15:0] duty_target,
	input logic [7:0]  percent_value
);
	import spcp_pkg::*;

	// An enable or disable reply shows the flag it has just set.
	a_enable_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (reply_kind == RPL_ENABLED || reply_kind == RPL_DISABLED))
		|-> (pwm_on == (reply_kind == RPL_ENABLED)))
		else $error("pwm_on does not match an enable or disable reply");

	// Only percentage replies carry a percentage.
	a_pct_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (reply_kind == RPL_ENABLED || reply_kind == RPL_DISABLED ||
			reply_kind == RPL_STATUS || reply_kind == RPL_UNKNOWN))
		|-> (percent_value == 8'd0))
		else $error("percent_value is not zero for a non-percentage reply");

	// Accept and reject follow the percentage limit.
	a_pct_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (reply_kind == RPL_DUTY_SET || reply_kind == RPL_REJECTED))
		|-> ((reply_kind == RPL_DUTY_SET) == (percent_value <= PERCENT_MAX)))
		else $error("duty set or rejected reply disagrees with the percentage");

	// A waiting result holds until it is taken.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(reply_kind) && $stable(pwm_on) &&
			$stable(duty_target) && $stable(percent_value)))
		else $error("waiting result changed before it was taken");

endmodule

bind serial_pwm_command_parser spcp_checker u_spcp_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for the serial PWM command parser: directed and random command lines.
// Uses spcp_pkg for the reply codes, character codes and result layout.
// Needs only the RTL of serial_pwm_command_parser.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import spcp_pkg::*;

	localparam int LINE_CAPACITY = 32;
	localparam int DRAIN_CYCLES  = 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [7:0]  rx_byte = 8'h00;
	logic        pop = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [15:0] cfg_data = 16'h0000;
	logic        full;
	logic        empty;
	logic [2:0]  reply_kind;
	logic        pwm_on;
	logic [15:0] duty_target;
	logic [7:0]  percent_value;
	logic        cfg_ready;

	// Idle rates, in percent, for the sender and the receiver.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	int failures = 0;
	int bytes_sent = 0;
	int lines_decoded = 0;
	int replies_checked = 0;
	int scale_writes = 0;

	// Expected reply words, oldest first.
	result_t replies_due[$];

	// Own copy of the parser state and of the full-scale register.
	logic [15:0] full_scale = FULL_SCALE_RESET;
	logic [4:0]  line_kept = '0;
	logic [7:0]  line_first = CHAR_NUL;
	logic        line_ended = 1'b0;
	logic        line_long = 1'b0;
	num_phase_t  num_phase = NUM_SKIP;
	logic        num_neg = 1'b0;
	logic [7:0]  num_accum = '0;
	logic        pwm_enabled = 1'b1;
	logic [15:0] duty_now = DUTY_RESET;

	serial_pwm_command_parser #(.LINE_CAPACITY(LINE_CAPACITY)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.rx_byte(rx_byte),
		.empty(empty),
		.pop(pop),
		.reply_kind(reply_kind),
		.pwm_on(pwm_on),
		.duty_target(duty_target),
		.percent_value(percent_value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Hard stop should the parser hang.
	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Updates the predicted state for one accepted byte and queues any reply it causes.
	task automatic parse_byte(input logic [7:0] b);
		result_t    reply;
		logic [7:0] pct;
		logic [4:0] idx;
		logic [7:0] folded;
		logic       digit;
		logic       blank;
		digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
		blank = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
		if (b == CHAR_LF || b == CHAR_CR) begin
			// A line end decodes only a line that kept something and whose text is not empty.
			if (line_kept != 0) begin
				if (line_first != CHAR_NUL) begin
					folded = line_first & CASE_MASK;
					pct = '0;
					if (folded == CHAR_L && !line_long) begin
						pwm_enabled = 1'b1;
						reply.kind = RPL_ENABLED;
					end else if (folded == CHAR_D && !line_long) begin
						pwm_enabled = 1'b0;
						reply.kind = RPL_DISABLED;
					end else if (folded == CHAR_S && !line_long) begin
						reply.kind = RPL_STATUS;
					end else if (folded == CHAR_P) begin
						pct = num_neg ? 8'(8'd0 - num_accum) : num_accum;
						if (pct <= PERCENT_MAX) begin
							duty_now = 16'((32'(full_scale) * 32'(pct)) / 32'd100);
							reply.kind = RPL_DUTY_SET;
						end else begin
							reply.kind = RPL_REJECTED;
						end
					end else begin
						reply.kind = RPL_UNKNOWN;
					end
					reply.pwm_on = pwm_enabled;
					reply.duty = duty_now;
					reply.pct = pct;
					replies_due.push_back(reply);
					lines_decoded++;
				end
				line_kept = '0;
				line_first = CHAR_NUL;
				line_ended = 1'b0;
				line_long = 1'b0;
				num_phase = NUM_SKIP;
				num_neg = 1'b0;
				num_accum = '0;
			end
		end else if (line_kept < 5'(LINE_CAPACITY - 1)) begin
			// Bytes beyond the first LINE_CAPACITY - 1 of a line are dropped; a zero byte ends the text.
			idx = line_kept;
			line_kept++;
			if (!line_ended) begin
				if (b == CHAR_NUL) begin
					line_ended = 1'b1;
				end else if (idx == 0) begin
					line_first = b;
				end else begin
					line_long = 1'b1;
					// Decimal reader: blanks, one optional sign, then digits.
					if (num_phase == NUM_SKIP) begin
						if (!blank) begin
							if (b == CHAR_PLUS || b == CHAR_MINUS) begin
								num_neg = (b == CHAR_MINUS);
								num_phase = NUM_DIGITS;
							end else if (digit) begin
								num_accum = b - CHAR_ZERO;
								num_phase = NUM_DIGITS;
							end else begin
								num_phase = NUM_DONE;
							end
						end
					end else if (num_phase == NUM_DIGITS) begin
						if (digit)
							num_accum = num_accum * 8'd10 + (b - CHAR_ZERO);
						else
							num_phase = NUM_DONE;
					end
				end
			end
		end
	endtask

	// Offers one byte, with random idle cycles first, and leaves push high once accepted.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		parse_byte(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Stops sending until every expected reply has been taken.
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (replies_due.size() != 0)
			@(posedge clk);
	endtask

	// Writes the full-scale register once the parser has gone quiet.
	task automatic write_full_scale(input logic [15:0] value);
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		full_scale = value;
		scale_writes++;
	endtask

	// Reports one field that differs from its expected value.
	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			failures++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// Receiver: takes reply words with random stalls and checks each against the oldest one due.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			if (replies_due.size() == 0) begin
				failures++;
				$display("%0t ns: unexpected reply, expected none, actual kind %0d duty %0d",
					$time, reply_kind, duty_target);
			end else begin
				want = replies_due.pop_front();
				check_field("reply_kind", want.kind, reply_kind);
				check_field("pwm_on", want.pwm_on, pwm_on);
				check_field("duty_target", want.duty, duty_target);
				check_field("percent_value", want.pct, percent_value);
				replies_checked++;
			end
		end
		pop <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Enable, disable and status letters in both cases, plus unknown and raw bytes.
	task automatic test_mode_commands();
		send_text("L\n");
		send_text("d\r");
		send_text("s\n");
		send_text("l\r\n");
		send_text("D\n");
		send_text("S\r");
		send_text("LX\n");
		send_text("X\n");
		send_byte(8'hFF);
		send_byte(CHAR_LF);
		send_byte(8'h80);
		send_byte(8'h7F);
		send_byte(CHAR_CR);
		settle();
	endtask

	// Percent lines: bounds, rejection, wrapping, signs, blanks and early ends of the text.
	task automatic test_percent_parsing();
		send_text("P100\n");
		send_text("p0\r");
		send_text("P101\n");
		send_text("P\n");
		send_text("P \t+42\n");
		send_text("P-156\n");
		send_text("P-1\n");
		send_text("p356\n");
		send_text("P12x9\n");
		send_byte(CHAR_P);
		send_byte(8'hFF);
		send_byte(CHAR_LF);
		// Zero byte inside the number, after a letter, and as the first byte.
		send_text("P5");
		send_byte(CHAR_NUL);
		send_text(" 9\n");
		send_text("L");
		send_byte(CHAR_NUL);
		send_text("Q\n");
		send_byte(CHAR_NUL);
		send_text("abc\n");
		settle();
	endtask

	// A line longer than the capacity: only the first bytes count.
	task automatic test_line_capacity();
		send_text("P0000000000000000000000000000079999\n");
		send_text("S0123456789012345678901234567890123\n");
		settle();
	endtask

	// Duty scaling at the smallest and largest full scale.
	task automatic test_full_scale_extremes();
		write_full_scale(16'd1);
		send_text("P100\n");
		send_text("P99\n");
		write_full_scale(16'hFFFF);
		send_text("P100\n");
		send_text("P50\n");
		send_text("P1\n");
		write_full_scale(FULL_SCALE_RESET);
		send_text("P33\n");
		settle();
	endtask

	// Builds and sends one random line: mostly well-formed commands, some noise.
	task automatic send_random_line();
		logic [7:0] line_q[$];
		logic [7:0] letters[6];
		logic [7:0] blanks[4];
		int         pick;
		letters = '{CHAR_L, CHAR_L | ~CASE_MASK, CHAR_D, CHAR_D | ~CASE_MASK,
			CHAR_S, CHAR_S | ~CASE_MASK};
		blanks = '{CHAR_SPACE, CHAR_TAB, CHAR_LF + 8'd1, CHAR_CR - 8'd1};
		pick = $urandom_range(99);
		if (pick < 20) begin
			line_q.push_back(letters[$urandom_range(5)]);
			if ($urandom_range(9) == 0) begin
				line_q.push_back(CHAR_NUL);
				line_q.push_back(8'($urandom_range(32, 126)));
			end
		end else if (pick < 55) begin
			line_q.push_back($urandom_range(1) ? CHAR_P : (CHAR_P | ~CASE_MASK));
			repeat ($urandom_range(2)) line_q.push_back(blanks[$urandom_range(3)]);
			case ($urandom_range(3))
				0: line_q.push_back(CHAR_PLUS);
				1: line_q.push_back(CHAR_MINUS);
				default: ;
			endcase
			repeat ($urandom_range(4)) line_q.push_back(CHAR_ZERO + 8'($urandom_range(9)));
			if ($urandom_range(5) == 0)
				line_q.push_back(8'($urandom_range(32, 126)));
		end else if (pick < 62) begin
			line_q.push_back(CHAR_P);
			repeat ($urandom_range(28, 40)) line_q.push_back(CHAR_ZERO + 8'($urandom_range(9)));
		end else if (pick < 72) begin
			// Nothing kept: an empty line.
		end else begin
			repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(255)));
		end
		case ($urandom_range(2))
			0: line_q.push_back(CHAR_LF);
			1: line_q.push_back(CHAR_CR);
			default: begin
				line_q.push_back(CHAR_CR);
				line_q.push_back(CHAR_LF);
			end
		endcase
		foreach (line_q[i])
			send_byte(line_q[i]);
	endtask

	// Random lines under one idling pattern, one new full scale, random full pauses.
	task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
		int start;
		write_full_scale(16'($urandom_range(1, 65535)));
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		start = bytes_sent;
		while (bytes_sent - start < count) begin
			send_random_line();
			if ($urandom_range(24) == 0)
				settle();
		end
		settle();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_mode_commands();
		test_percent_parsing();
		test_line_capacity();
		test_full_scale_extremes();
		test_random_traffic(0, 0, 55);
		test_random_traffic(64, 0, 55);
		test_random_traffic(0, 64, 55);
		test_random_traffic(8, 8, 55);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d bytes making %0d decoded lines; %0d replies checked.",
			bytes_sent, lines_decoded, replies_checked);
		$display("Full scale written %0d times, under four idling patterns.", scale_writes);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
